// ----- rtl/fbfl_pkg.sv -----
`default_nettype none
package fbfl_pkg;

  localparam int MAX_BLOCKS = 256;
  localparam int IDX_W = $clog2(MAX_BLOCKS);
  localparam int LINK_W = IDX_W + 1;
  localparam logic [LINK_W-1:0] END_MARK = LINK_W'(MAX_BLOCKS);

  localparam logic [1:0] REG_BASE = 2'd0;
  localparam logic [1:0] REG_SIZE = 2'd1;
  localparam logic [1:0] REG_COUNT = 2'd2;

  typedef enum logic [1:0] {
    MODE_ALLOC = 2'd0,
    MODE_FREE = 2'd1,
    MODE_REBUILD = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef struct packed {
    mode_t mode;
    logic [7:0] block_index;
  } cmd_t;

  typedef struct packed {
    status_t status;
    logic [7:0] granted_index;
    logic [31:0] granted_address;
  } result_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ALLOC,
    S_POP,
    S_FREE,
    S_BUILD,
    S_NOP
  } state_t;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_FREE,
    WR_BUILD
  } wr_sel_t;

  typedef enum logic [2:0] {
    HEAD_HOLD,
    HEAD_POP,
    HEAD_PUSH,
    HEAD_ZERO,
    HEAD_END
  } head_sel_t;

  typedef struct packed {
    logic latch;
    logic mem_rd;
    wr_sel_t wr_sel;
    head_sel_t head_sel;
    logic cnt_inc;
    logic resp;
    status_t resp_status;
    logic resp_grant;
  } ctrl_cmd_t;

  typedef struct packed {
    logic head_end;
    logic free_oob;
    logic build_zero;
    logic build_last;
  } dp_stat_t;

endpackage
`default_nettype wire

// ----- rtl/fbfl_ctrl.sv -----
`default_nettype none
module fbfl_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire fbfl_pkg::mode_t      mode,
  input  wire fbfl_pkg::dp_stat_t   st,
  output fbfl_pkg::ctrl_cmd_t       cmds,
  output logic                      busy
);

  fbfl_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fbfl_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      fbfl_pkg::S_IDLE: begin
        if (start) begin
          case (mode)
            fbfl_pkg::MODE_ALLOC:   state_next = fbfl_pkg::S_ALLOC;
            fbfl_pkg::MODE_FREE:    state_next = fbfl_pkg::S_FREE;
            fbfl_pkg::MODE_REBUILD: state_next = fbfl_pkg::S_BUILD;
            default:                state_next = fbfl_pkg::S_NOP;
          endcase
        end
      end
      fbfl_pkg::S_ALLOC: begin
        state_next = st.head_end ? fbfl_pkg::S_IDLE : fbfl_pkg::S_POP;
      end
      fbfl_pkg::S_BUILD: begin
        if (st.build_zero || st.build_last) begin
          state_next = fbfl_pkg::S_IDLE;
        end
      end
      fbfl_pkg::S_POP,
      fbfl_pkg::S_FREE,
      fbfl_pkg::S_NOP: state_next = fbfl_pkg::S_IDLE;
      default: state_next = fbfl_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmds = '0;
    cmds.wr_sel = fbfl_pkg::WR_NONE;
    cmds.head_sel = fbfl_pkg::HEAD_HOLD;
    cmds.resp_status = fbfl_pkg::ST_OK;
    busy = 1'b1;
    case (state)
      fbfl_pkg::S_IDLE: begin
        busy = 1'b0;
        cmds.latch = start;
      end
      fbfl_pkg::S_ALLOC: begin
        if (st.head_end) begin
          cmds.resp = 1'b1;
          cmds.resp_status = fbfl_pkg::ST_EMPTY;
        end else begin
          cmds.mem_rd = 1'b1;
        end
      end
      fbfl_pkg::S_POP: begin
        cmds.head_sel = fbfl_pkg::HEAD_POP;
        cmds.resp = 1'b1;
        cmds.resp_grant = 1'b1;
      end
      fbfl_pkg::S_FREE: begin
        cmds.resp = 1'b1;
        if (st.free_oob) begin
          cmds.resp_status = fbfl_pkg::ST_RANGE;
        end else begin
          cmds.wr_sel = fbfl_pkg::WR_FREE;
          cmds.head_sel = fbfl_pkg::HEAD_PUSH;
        end
      end
      fbfl_pkg::S_BUILD: begin
        if (st.build_zero) begin
          cmds.head_sel = fbfl_pkg::HEAD_END;
          cmds.resp = 1'b1;
        end else begin
          cmds.wr_sel = fbfl_pkg::WR_BUILD;
          cmds.cnt_inc = 1'b1;
          if (st.build_last) begin
            cmds.head_sel = fbfl_pkg::HEAD_ZERO;
            cmds.resp = 1'b1;
          end
        end
      end
      fbfl_pkg::S_NOP: begin
        cmds.resp = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/fbfl_dp.sv -----
`default_nettype none
module fbfl_dp (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic [7:0]            block_index,
  input  wire logic                  cfg_valid,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [31:0]           cfg_data,
  input  wire fbfl_pkg::ctrl_cmd_t   cmds,
  output fbfl_pkg::dp_stat_t         st,
  output logic                       done,
  output fbfl_pkg::result_t          result
);

  logic [31:0] base_address;
  logic [15:0] block_size;
  logic [8:0] block_count;

  logic [7:0] index_q;
  logic [fbfl_pkg::LINK_W-1:0] head;
  logic [fbfl_pkg::LINK_W-1:0] head_next;
  logic [fbfl_pkg::IDX_W-1:0] cnt;
  logic [fbfl_pkg::LINK_W-1:0] link_store [fbfl_pkg::MAX_BLOCKS];
  logic [fbfl_pkg::LINK_W-1:0] rdata;
  logic [23:0] prod;

  logic [8:0] eff_count;
  logic [fbfl_pkg::LINK_W-1:0] cnt_plus;
  logic [fbfl_pkg::IDX_W-1:0] wr_addr;
  logic [fbfl_pkg::LINK_W-1:0] wr_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_address <= '0;
      block_size <= 16'd1;
      block_count <= 9'd256;
    end else if (cfg_valid) begin
      case (cfg_index)
        fbfl_pkg::REG_BASE:  base_address <= cfg_data;
        fbfl_pkg::REG_SIZE:  block_size <= cfg_data[15:0];
        fbfl_pkg::REG_COUNT: block_count <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // A count above the pool capacity is taken as the capacity.
  assign eff_count = (block_count > 9'(fbfl_pkg::MAX_BLOCKS)) ?
                     9'(fbfl_pkg::MAX_BLOCKS) : block_count;
  assign cnt_plus = {1'b0, cnt} + fbfl_pkg::LINK_W'(1);

  assign st.head_end = (head >= fbfl_pkg::END_MARK);
  assign st.free_oob = ({1'b0, index_q} >= eff_count);
  assign st.build_zero = (eff_count == 9'd0);
  assign st.build_last = (cnt_plus == eff_count);

  always_ff @(posedge clk) begin
    if (cmds.latch) begin
      index_q <= block_index;
    end
  end

  always_ff @(posedge clk) begin
    if (cmds.latch) begin
      cnt <= '0;
    end else if (cmds.cnt_inc) begin
      cnt <= cnt_plus[fbfl_pkg::IDX_W-1:0];
    end
  end

  always_comb begin
    if (cmds.wr_sel == fbfl_pkg::WR_BUILD) begin
      wr_addr = cnt;
      wr_data = st.build_last ? fbfl_pkg::END_MARK : cnt_plus;
    end else begin
      wr_addr = index_q;
      wr_data = head;
    end
  end

  always_ff @(posedge clk) begin
    if (cmds.wr_sel != fbfl_pkg::WR_NONE) begin
      link_store[wr_addr] <= wr_data;
    end
    if (cmds.mem_rd) begin
      rdata <= link_store[head[fbfl_pkg::IDX_W-1:0]];
      prod <= {16'd0, head[fbfl_pkg::IDX_W-1:0]} * {8'd0, block_size};
    end
  end

  always_comb begin
    case (cmds.head_sel)
      fbfl_pkg::HEAD_POP:  head_next = (rdata > fbfl_pkg::END_MARK) ?
                                       fbfl_pkg::END_MARK : rdata;
      fbfl_pkg::HEAD_PUSH: head_next = {1'b0, index_q};
      fbfl_pkg::HEAD_ZERO: head_next = '0;
      fbfl_pkg::HEAD_END:  head_next = fbfl_pkg::END_MARK;
      default:             head_next = head;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= fbfl_pkg::END_MARK;
      done <= 1'b0;
    end else begin
      head <= head_next;
      done <= cmds.resp;
    end
  end

  // The result is taken while head still holds the block being popped.
  always_ff @(posedge clk) begin
    if (cmds.resp) begin
      result.status <= cmds.resp_status;
      if (cmds.resp_grant) begin
        result.granted_index <= head[fbfl_pkg::IDX_W-1:0];
        result.granted_address <= base_address + {8'd0, prod};
      end else begin
        result.granted_index <= '0;
        result.granted_address <= '0;
      end
    end
  end

  a_head_bounded: assert property (@(posedge clk) disable iff (rst)
    head <= fbfl_pkg::END_MARK)
    else $error("free list head beyond end mark");

  a_reset_empty: assert property (@(posedge clk)
    !rst && $past(rst) |-> head == fbfl_pkg::END_MARK)
    else $error("pool not empty after reset");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    done && result.status != fbfl_pkg::ST_OK |->
      result.granted_index == '0 && result.granted_address == '0)
    else $error("failed transfer carries a grant");

  a_range_no_write: assert property (@(posedge clk) disable iff (rst)
    cmds.resp && cmds.resp_status == fbfl_pkg::ST_RANGE |->
      cmds.wr_sel == fbfl_pkg::WR_NONE && cmds.head_sel == fbfl_pkg::HEAD_HOLD)
    else $error("out of range free changed the list");

endmodule
`default_nettype wire

// ----- rtl/fixed_block_free_list_allocator.sv -----
`default_nettype none
// Fixed-size block pool managed as a linked free list of block indices.
// Command channel: cmd is taken at a rising edge with start high and busy low.
// Mode allocate pops the list head, free pushes cmd.block_index, rebuild
// links blocks 0 to block_count-1 in order with the head at block 0.
// Every command gives one result on result, marked by done for one cycle;
// the receiver cannot hold it off, and a new command may be started in the
// cycle that done is high.
// Allocate passes through S_ALLOC and S_POP (an empty pool answers from
// S_ALLOC); free answers from S_FREE, an unused mode from S_NOP, and rebuild
// walks n blocks, n the block_count capped at 256 (no writes for n zero).
// The rebuild walk writes one link entry per cycle through the single write
// port of the link memory, and allocate waits on the registered link read.
// Configuration: cfg_index/cfg_data are written when cfg_valid and cfg_ready
// are both high; cfg_ready is always high. Write only while idle.
// Reset leaves the pool empty (head at the end mark) and the registers at
// base 0, block size 1, count 256. The link memory is not cleared; run a
// rebuild before the first allocate.
module fixed_block_free_list_allocator (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  input  wire fbfl_pkg::cmd_t      cmd,
  output logic                     done,
  output fbfl_pkg::result_t        result,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [31:0]         cfg_data
);

  fbfl_pkg::ctrl_cmd_t cmds;
  fbfl_pkg::dp_stat_t st;

  assign cfg_ready = 1'b1;

  fbfl_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .mode (cmd.mode),
    .st   (st),
    .cmds (cmds),
    .busy (busy)
  );

  fbfl_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .block_index(cmd.block_index),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmds       (cmds),
    .st         (st),
    .done       (done),
    .result     (result)
  );

endmodule
`default_nettype wire
